/* sv/upa_pkg.sv */
// ============================================================================
// upa_pkg: shared types, constants and microcode for the uplink allocator
// Holds the word types, the configuration view, the control and status
// structs between sequencer and datapath, and the microcode table.
// ============================================================================
package upa_pkg;

    localparam int MAX_PACKETS_DEF = 16;
    localparam int CAP_MAX         = 127;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_PACKET_LIMIT   = 3'd0;
    localparam logic [2:0] REG_GUARANTEED     = 3'd1;
    localparam logic [2:0] REG_TOPOLOGY_BYTES = 3'd2;
    localparam logic [2:0] REG_RECORD_BYTES   = 3'd3;
    localparam logic [2:0] REG_FIRST_CAP      = 3'd4;
    localparam logic [2:0] REG_OTHER_CAP      = 3'd5;

    typedef struct packed {
        logic [7:0] available_topologies;
        logic [7:0] available_records;
    } in_word_t;

    typedef struct packed {
        logic [7:0] topologies_sent;
        logic [7:0] records_sent;
        logic [4:0] packets_used;
    } out_word_t;

    typedef struct packed {
        logic [4:0] packet_limit;
        logic [7:0] guaranteed_topologies;
        logic [6:0] topology_bytes;
        logic [6:0] record_bytes;
        logic [6:0] first_capacity;
        logic [6:0] other_capacity;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_TOTAL,
        OP_BUDGET,
        OP_DIVB_S,
        OP_MIN_S,
        OP_REM_S,
        OP_DIVB_T,
        OP_ADD_T,
        OP_INIT_T,
        OP_DIVR_T,
        OP_TAKE,
        OP_ROOM_T,
        OP_NEXT,
        OP_FIN_T,
        OP_DIVR_S,
        OP_ROOM_S,
        OP_FIN_S,
        OP_OUTPUT
    } uop_t;

    typedef enum logic [2:0] {
        CND_NONE,
        CND_JUMP,
        CND_EXIT,
        CND_HOLD_IN,
        CND_HOLD_DIV,
        CND_HOLD_OUT
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } mc_word_t;

    typedef struct packed {
        uop_t op;
    } ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
        logic loop_exit;
    } status_t;

    // Program labels.
    localparam step_t L_IDLE   = 5'd0;
    localparam step_t L_PACK_T = 5'd11;
    localparam step_t L_END_T  = 5'd16;
    localparam step_t L_PACK_S = 5'd17;
    localparam step_t L_END_S  = 5'd22;

    function automatic mc_word_t mc_fetch(input step_t step);
        mc_word_t w;
        w = '{op: OP_NOP, cond: CND_JUMP, target: L_IDLE};
        case (step)
            5'd0:  w = '{op: OP_LOAD,   cond: CND_HOLD_IN,  target: L_IDLE};
            5'd1:  w = '{op: OP_TOTAL,  cond: CND_NONE,     target: L_IDLE};
            5'd2:  w = '{op: OP_BUDGET, cond: CND_NONE,     target: L_IDLE};
            5'd3:  w = '{op: OP_DIVB_S, cond: CND_NONE,     target: L_IDLE};
            5'd4:  w = '{op: OP_NOP,    cond: CND_HOLD_DIV, target: L_IDLE};
            5'd5:  w = '{op: OP_MIN_S,  cond: CND_NONE,     target: L_IDLE};
            5'd6:  w = '{op: OP_REM_S,  cond: CND_NONE,     target: L_IDLE};
            5'd7:  w = '{op: OP_DIVB_T, cond: CND_NONE,     target: L_IDLE};
            5'd8:  w = '{op: OP_NOP,    cond: CND_HOLD_DIV, target: L_IDLE};
            5'd9:  w = '{op: OP_ADD_T,  cond: CND_NONE,     target: L_IDLE};
            5'd10: w = '{op: OP_INIT_T, cond: CND_NONE,     target: L_IDLE};
            5'd11: w = '{op: OP_DIVR_T, cond: CND_NONE,     target: L_IDLE};
            5'd12: w = '{op: OP_NOP,    cond: CND_HOLD_DIV, target: L_IDLE};
            5'd13: w = '{op: OP_TAKE,   cond: CND_NONE,     target: L_IDLE};
            5'd14: w = '{op: OP_ROOM_T, cond: CND_EXIT,     target: L_END_T};
            5'd15: w = '{op: OP_NEXT,   cond: CND_JUMP,     target: L_PACK_T};
            5'd16: w = '{op: OP_FIN_T,  cond: CND_NONE,     target: L_IDLE};
            5'd17: w = '{op: OP_DIVR_S, cond: CND_NONE,     target: L_IDLE};
            5'd18: w = '{op: OP_NOP,    cond: CND_HOLD_DIV, target: L_IDLE};
            5'd19: w = '{op: OP_TAKE,   cond: CND_NONE,     target: L_IDLE};
            5'd20: w = '{op: OP_ROOM_S, cond: CND_EXIT,     target: L_END_S};
            5'd21: w = '{op: OP_NEXT,   cond: CND_JUMP,     target: L_PACK_S};
            5'd22: w = '{op: OP_FIN_S,  cond: CND_NONE,     target: L_IDLE};
            5'd23: w = '{op: OP_OUTPUT, cond: CND_HOLD_OUT, target: L_IDLE};
            5'd24: w = '{op: OP_NOP,    cond: CND_JUMP,     target: L_IDLE};
            default: w = '{op: OP_NOP, cond: CND_JUMP, target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* sv/upa_div.sv */
// ============================================================================
// upa_div: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend by a 7-bit nonzero divisor and holds the
// quotient until the next start.
// ============================================================================
module upa_div #(
    parameter int DIVIDEND_W = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [6:0]            divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [6:0]            rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [6:0]            dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [7:0]            shifted;
    logic [7:0]            trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[6:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[6:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/upa_seq.sv */
// ============================================================================
// upa_seq: microcode sequencer
// Steps through the allocation program, handling holds, loop exits and
// jumps, and issues one datapath operation per step.
// ============================================================================
module upa_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  upa_pkg::status_t  st,
    output upa_pkg::ctrl_t    ctrl,
    output logic              in_ready
);
    import upa_pkg::*;

    step_t    step_reg, step_next;
    mc_word_t word;
    logic     hold;

    always_comb
    begin
        word = mc_fetch(step_reg);
        case (word.cond)
            CND_HOLD_IN:  hold = !in_valid;
            CND_HOLD_DIV: hold = st.div_busy;
            CND_HOLD_OUT: hold = st.out_full;
            default:      hold = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (word.cond == CND_JUMP || (word.cond == CND_EXIT && st.loop_exit))
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_comb
    begin
        ctrl.op  = hold ? OP_NOP : word.op;
        in_ready = (word.op == OP_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= L_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* sv/upa_dp.sv */
// ============================================================================
// upa_dp: allocation datapath
// Budget accumulator, record counters, packet room and packet count, the
// divider operand select and the output word register.
// ============================================================================
module upa_dp #(
    parameter int MAX_PACKETS = 16,
    parameter int ACC_W       = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  upa_pkg::ctrl_t       ctrl,
    input  upa_pkg::cfg_t        cfg,
    input  upa_pkg::in_word_t    in_data,
    input  logic                 out_ready,
    output upa_pkg::status_t     st,
    output logic                 out_valid,
    output upa_pkg::out_word_t   out_data,
    output logic                 div_start,
    output logic [ACC_W-1:0]     div_dividend,
    output logic [6:0]           div_divisor,
    input  logic                 div_busy,
    input  logic [ACC_W-1:0]     div_quot
);
    import upa_pkg::*;

    localparam int PKT_W  = $clog2(MAX_PACKETS + 1);
    localparam int PROD_W = PKT_W + 7;
    localparam int CMP_W  = (ACC_W > 15) ? ACC_W : 15;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [7:0]       num_t_reg, num_t_next;
    logic [7:0]       rest_t_reg, rest_t_next;
    logic [7:0]       num_s_reg, num_s_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       take_reg, take_next;
    logic [6:0]       room_reg, room_next;
    logic [PKT_W-1:0] packets_reg, packets_next;
    logic [PKT_W-1:0] lim_reg, lim_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    logic [6:0]        tsize, ssize;
    logic [7:0]        guar_min;
    logic [PROD_W-1:0] prod_total;
    logic [14:0]       t_bytes;
    logic [14:0]       s_bytes;
    logic [14:0]       room_used_t;
    logic [14:0]       room_used_s;
    logic [7:0]        q_min_s, q_min_rest, q_min_left;

    always_comb
    begin
        tsize = (cfg.topology_bytes == 7'd0) ? 7'd1 : cfg.topology_bytes;
        ssize = (cfg.record_bytes == 7'd0) ? 7'd1 : cfg.record_bytes;
        guar_min = (cfg.guaranteed_topologies < in_data.available_topologies)
                 ? cfg.guaranteed_topologies : in_data.available_topologies;
        prod_total  = PROD_W'(lim_reg - PKT_W'(1)) * PROD_W'(cfg.other_capacity);
        t_bytes     = 15'(num_t_reg) * 15'(tsize);
        s_bytes     = 15'(num_s_reg) * 15'(ssize);
        room_used_t = 15'(take_reg) * 15'(tsize);
        room_used_s = 15'(take_reg) * 15'(ssize);
        q_min_s    = (CMP_W'(div_quot) < CMP_W'(num_s_reg)) ? 8'(div_quot) : num_s_reg;
        q_min_rest = (CMP_W'(div_quot) < CMP_W'(rest_t_reg)) ? 8'(div_quot) : rest_t_reg;
        q_min_left = (CMP_W'(div_quot) < CMP_W'(left_reg)) ? 8'(div_quot) : left_reg;
    end

    // Divider operands.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = acc_reg;
        div_divisor  = ssize;
        case (ctrl.op)
            OP_DIVB_S:
            begin
                div_start = 1'b1;
            end
            OP_DIVB_T:
            begin
                div_start   = 1'b1;
                div_divisor = tsize;
            end
            OP_DIVR_T:
            begin
                div_start    = 1'b1;
                div_dividend = ACC_W'(room_reg);
                div_divisor  = tsize;
            end
            OP_DIVR_S:
            begin
                div_start    = 1'b1;
                div_dividend = ACC_W'(room_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        acc_next     = acc_reg;
        num_t_next   = num_t_reg;
        rest_t_next  = rest_t_reg;
        num_s_next   = num_s_reg;
        left_next    = left_reg;
        take_next    = take_reg;
        room_next    = room_reg;
        packets_next = packets_reg;
        lim_next     = lim_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (ctrl.op)
            OP_LOAD:
            begin
                num_t_next   = guar_min;
                rest_t_next  = in_data.available_topologies - guar_min;
                num_s_next   = in_data.available_records;
                acc_next     = ACC_W'(cfg.first_capacity);
                packets_next = PKT_W'(1);
                if (cfg.packet_limit == 5'd0)
                begin
                    lim_next = PKT_W'(1);
                end
                else if (int'(cfg.packet_limit) > MAX_PACKETS)
                begin
                    lim_next = PKT_W'(MAX_PACKETS);
                end
                else
                begin
                    lim_next = PKT_W'(cfg.packet_limit);
                end
            end
            OP_TOTAL:
            begin
                acc_next = acc_reg + ACC_W'(prod_total);
            end
            OP_BUDGET:
            begin
                // A budget that goes negative is clamped to zero.
                if (CMP_W'(t_bytes) > CMP_W'(acc_reg))
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_reg - ACC_W'(t_bytes);
                end
            end
            OP_MIN_S:
            begin
                num_s_next = q_min_s;
            end
            OP_REM_S:
            begin
                acc_next = acc_reg - ACC_W'(s_bytes);
            end
            OP_ADD_T:
            begin
                num_t_next = num_t_reg + q_min_rest;
            end
            OP_INIT_T:
            begin
                room_next    = cfg.first_capacity;
                packets_next = PKT_W'(1);
                left_next    = num_t_reg;
            end
            OP_TAKE:
            begin
                take_next = q_min_left;
                left_next = left_reg - q_min_left;
            end
            OP_ROOM_T:
            begin
                room_next = room_reg - 7'(room_used_t);
            end
            OP_ROOM_S:
            begin
                room_next = room_reg - 7'(room_used_s);
            end
            OP_NEXT:
            begin
                packets_next = packets_reg + PKT_W'(1);
                room_next    = cfg.other_capacity;
            end
            OP_FIN_T:
            begin
                num_t_next = num_t_reg - left_reg;
                left_next  = num_s_reg;
            end
            OP_FIN_S:
            begin
                num_s_next = num_s_reg - left_reg;
            end
            OP_OUTPUT:
            begin
                out_next.topologies_sent = num_t_reg;
                out_next.records_sent    = num_s_reg;
                out_next.packets_used    = 5'(packets_reg);
                out_valid_next           = 1'b1;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            packets_reg   <= PKT_W'(1);
            lim_reg       <= PKT_W'(1);
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            packets_reg   <= packets_next;
            lim_reg       <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        num_t_reg  <= num_t_next;
        rest_t_reg <= rest_t_next;
        num_s_reg  <= num_s_next;
        left_reg   <= left_next;
        take_reg   <= take_next;
        room_reg   <= room_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        st.div_busy  = div_busy;
        st.out_full  = out_valid_reg && !out_ready;
        st.loop_exit = (left_reg == 8'd0) || (packets_reg >= lim_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_quot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_MIN_S || ctrl.op == OP_ADD_T || ctrl.op == OP_TAKE) |-> !div_busy)
        else $error("quotient used before the divider finished");

    a_pkt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (packets_reg <= lim_reg) && (packets_reg != '0))
        else $error("packet count outside the limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_OUTPUT) |-> !(out_valid_reg && !out_ready))
        else $error("output word overwritten before it was taken");

endmodule

/* sv/uplink_packet_allocation_top.sv */
// ============================================================================
// uplink_packet_allocation_top: uplink message record allocator
// Decides how many topology and management records fit into one
// multi-packet uplink message and how many packets that message uses.
// ============================================================================
// One word at a time is computed by a microcoded sequencer driving a small
// datapath with a shared restoring divider that resolves one quotient bit per
// cycle (D = clog2(127*MAX_PACKETS+1) bits, 11 at the default). Each word
// runs a budget pass with two divisions outside the packing loops, then the
// topology packing loop and the management packing loop; each loop divides
// once for every packet visited and opens the next packet when it goes on.
// The result waits in the output register for the consumer while the next
// word is computed; the program stalls before loading the following result
// until that register is free, and after a result is loaded it jumps back
// to the load step to take the next word.
// Configuration registers may be written only while no word is in flight.
module uplink_packet_allocation_top #(
    parameter int MAX_PACKETS = upa_pkg::MAX_PACKETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  upa_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output upa_pkg::out_word_t  out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import upa_pkg::*;

    localparam int ACC_W = $clog2(CAP_MAX * MAX_PACKETS + 1);

    cfg_t    cfg_reg, cfg_next;
    ctrl_t   ctrl;
    status_t st;

    logic             div_start;
    logic [ACC_W-1:0] div_dividend;
    logic [6:0]       div_divisor;
    logic             div_busy;
    logic [ACC_W-1:0] div_quot;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PACKET_LIMIT:   cfg_next.packet_limit          = cfg_wdata[4:0];
                REG_GUARANTEED:     cfg_next.guaranteed_topologies = cfg_wdata;
                REG_TOPOLOGY_BYTES: cfg_next.topology_bytes        = cfg_wdata[6:0];
                REG_RECORD_BYTES:   cfg_next.record_bytes          = cfg_wdata[6:0];
                REG_FIRST_CAP:      cfg_next.first_capacity        = cfg_wdata[6:0];
                REG_OTHER_CAP:      cfg_next.other_capacity        = cfg_wdata[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packet_limit          <= 5'd4;
            cfg_reg.guaranteed_topologies <= 8'd1;
            cfg_reg.topology_bytes        <= 7'd16;
            cfg_reg.record_bytes          <= 7'd8;
            cfg_reg.first_capacity        <= 7'd100;
            cfg_reg.other_capacity        <= 7'd120;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    upa_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    upa_dp #(
        .MAX_PACKETS (MAX_PACKETS),
        .ACC_W       (ACC_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg_reg),
        .in_data      (in_data),
        .out_ready    (out_ready),
        .st           (st),
        .out_valid    (out_valid),
        .out_data     (out_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_quot     (div_quot)
    );

    upa_div #(
        .DIVIDEND_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

endmodule

/* test/upa_allocation_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// upa_allocation_checker: result predictor and comparator for the allocator
// Mirrors the configuration registers from the write port, predicts the
// allocation for every accepted request word and compares each accepted
// result word with the oldest prediction still waiting.
// ============================================================================
module upa_allocation_checker #(
    parameter int MAX_PACKETS = upa_pkg::MAX_PACKETS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  upa_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  upa_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    output int                 fail_count,
    output int                 pending_words
);
    import upa_pkg::*;

    cfg_t      shadow_cfg;
    out_word_t predicted_allocs[$];
    int        mismatches;

    function automatic int smaller(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Places up to count records of the given size packet by packet and
    // returns how many were placed; room and packets carry over between calls.
    function automatic int pack_records(input int count, input int size, input int limit,
                                        input int later_room, inout int room,
                                        inout int packets);
        int left;
        int take;
        left = count;
        forever
        begin
            take = smaller(left, room / size);
            left -= take;
            room -= take * size;
            if (left == 0 || packets >= limit)
                break;
            packets++;
            room = later_room;
        end
        return count - left;
    endfunction

    function automatic out_word_t predict_allocation(input in_word_t req, input cfg_t c);
        int        limit;
        int        tsz;
        int        ssz;
        int        total;
        int        topo_n;
        int        topo_rest;
        int        budget;
        int        rec_n;
        int        spare;
        int        room;
        int        packets;
        out_word_t res;
        limit = int'(c.packet_limit);
        if (limit < 1)
            limit = 1;
        if (limit > MAX_PACKETS)
            limit = MAX_PACKETS;
        tsz = (c.topology_bytes == 0) ? 1 : int'(c.topology_bytes);
        ssz = (c.record_bytes == 0) ? 1 : int'(c.record_bytes);

        // Budget pass over the bytes of all packets together.
        total = int'(c.first_capacity) + (limit - 1) * int'(c.other_capacity);
        topo_n = smaller(int'(c.guaranteed_topologies), int'(req.available_topologies));
        topo_rest = int'(req.available_topologies) - topo_n;
        budget = total - topo_n * tsz;
        if (budget < 0)
            budget = 0;
        rec_n = smaller(int'(req.available_records), budget / ssz);
        spare = budget - rec_n * ssz;
        topo_n += smaller(spare / tsz, topo_rest);

        // Packing pass: topologies first, management records after them.
        room = int'(c.first_capacity);
        packets = 1;
        topo_n = pack_records(topo_n, tsz, limit, int'(c.other_capacity), room, packets);
        rec_n = pack_records(rec_n, ssz, limit, int'(c.other_capacity), room, packets);

        res.topologies_sent = 8'(topo_n);
        res.records_sent = 8'(rec_n);
        res.packets_used = 5'(packets);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            shadow_cfg.packet_limit = 5'd4;
            shadow_cfg.guaranteed_topologies = 8'd1;
            shadow_cfg.topology_bytes = 7'd16;
            shadow_cfg.record_bytes = 7'd8;
            shadow_cfg.first_capacity = 7'd100;
            shadow_cfg.other_capacity = 7'd120;
            predicted_allocs.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_words <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_allocs.push_back(predict_allocation(in_data, shadow_cfg));

            if (out_valid && out_ready)
            begin
                if (predicted_allocs.size() == 0)
                begin
                    $error("result word with no request waiting: %0d %0d %0d",
                           out_data.topologies_sent, out_data.records_sent,
                           out_data.packets_used);
                    mismatches++;
                end
                else
                begin
                    want = predicted_allocs.pop_front();
                    if (out_data.topologies_sent !== want.topologies_sent)
                    begin
                        $error("topologies_sent: expected %0d, actual %0d",
                               want.topologies_sent, out_data.topologies_sent);
                        mismatches++;
                    end
                    if (out_data.records_sent !== want.records_sent)
                    begin
                        $error("records_sent: expected %0d, actual %0d",
                               want.records_sent, out_data.records_sent);
                        mismatches++;
                    end
                    if (out_data.packets_used !== want.packets_used)
                    begin
                        $error("packets_used: expected %0d, actual %0d",
                               want.packets_used, out_data.packets_used);
                        mismatches++;
                    end
                end
            end

            // Writes come only while idle, so they never race a prediction.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PACKET_LIMIT:   shadow_cfg.packet_limit = cfg_wdata[4:0];
                    REG_GUARANTEED:     shadow_cfg.guaranteed_topologies = cfg_wdata;
                    REG_TOPOLOGY_BYTES: shadow_cfg.topology_bytes = cfg_wdata[6:0];
                    REG_RECORD_BYTES:   shadow_cfg.record_bytes = cfg_wdata[6:0];
                    REG_FIRST_CAP:      shadow_cfg.first_capacity = cfg_wdata[6:0];
                    REG_OTHER_CAP:      shadow_cfg.other_capacity = cfg_wdata[6:0];
                    default:            ;
                endcase
            end

            fail_count <= mismatches;
            pending_words <= predicted_allocs.size();
        end
    end

endmodule

/* test/uplink_packet_allocation_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// uplink_packet_allocation_top_tb: stimulus and verdict for the allocator
// Runs directed corner settings and then randomized settings with random
// request words, bursty input and a stalling consumer; the checker beside
// the block predicts and compares every result word.
// ============================================================================
module uplink_packet_allocation_top_tb;
    import upa_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 230;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 600;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;
    int         fail_count;
    int         pending_words;
    bit         hold_req = 1'b0;

    uplink_packet_allocation_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    upa_allocation_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd50_000_000);
        $display("status: fail");
        $finish;
    end

    task automatic send_word(input in_word_t w);
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Waits until every predicted result has been taken, then waits out the settle time.
    task automatic settle();
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic [2:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] lim, input logic [7:0] guar,
                                  input logic [7:0] tbytes, input logic [7:0] rbytes,
                                  input logic [7:0] fcap, input logic [7:0] ocap);
        program_register(REG_PACKET_LIMIT, lim);
        program_register(REG_GUARANTEED, guar);
        program_register(REG_TOPOLOGY_BYTES, tbytes);
        program_register(REG_RECORD_BYTES, rbytes);
        program_register(REG_FIRST_CAP, fcap);
        program_register(REG_OTHER_CAP, ocap);
        cfg_we <= 1'b0;
    endtask

    function automatic in_word_t random_request();
        in_word_t w;
        case ($urandom_range(0, 3))
            0:       w = {8'($urandom), 8'($urandom)};
            1:       w = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
            2:       w = {($urandom_range(0, 1) ? 8'hFF : 8'h00),
                          ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
            default: w = {8'($urandom_range(0, 20)), 8'($urandom)};
        endcase
        return w;
    endfunction

    // Sends count random words in bursts; optionally requests a long consumer
    // hold-off or pauses until drained at the given word positions.
    task automatic run_items(input int count, input int hold_at, input int drain_at);
        int burst;
        int gap;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == drain_at)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_words != 0)
                    @(posedge clk);
            end
            send_word(random_request());
            burst--;
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    gap = 0;
                else if ($urandom_range(0, 9) == 0)
                    gap = $urandom_range(50, 400);
                else
                    gap = $urandom_range(1, 30);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 40);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Consumer: ready follows a randomly chosen pattern for random spans.
    initial
    begin
        int mode;
        int span;
        int tick;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ((tick % 8) < 5);
                    endcase
                end
            end
        end
    end

    initial
    begin
        logic [7:0] lim;
        logic [7:0] guar;
        logic [7:0] tbytes;
        logic [7:0] rbytes;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Settings after reset.
        settle();
        send_word({8'd0, 8'd0});
        send_word({8'd255, 8'd255});
        send_word({8'd1, 8'd200});
        send_word({8'd200, 8'd3});
        in_valid <= 1'b0;

        // Writes to unused indexes must leave the settings alone.
        settle();
        program_register(REG_SPARE_A, 8'hFF);
        program_register(REG_SPARE_B, 8'h00);
        cfg_we <= 1'b0;
        send_word({8'd10, 8'd10});
        send_word({8'd3, 8'd40});
        in_valid <= 1'b0;

        // Packet limit zero with guaranteed topologies beyond the budget.
        settle();
        apply_settings(8'd0, 8'd255, 8'd127, 8'd127, 8'd127, 8'd127);
        send_word({8'd255, 8'd255});
        send_word({8'd5, 8'd5});
        in_valid <= 1'b0;

        // Limit above the maximum and zero record sizes.
        settle();
        apply_settings(8'd31, 8'd0, 8'd0, 8'd0, 8'd127, 8'd127);
        send_word({8'd255, 8'd255});
        send_word({8'd128, 8'd127});
        in_valid <= 1'b0;

        // No room at all: every packet visited, nothing placed.
        settle();
        apply_settings(8'd16, 8'd255, 8'd1, 8'd1, 8'd0, 8'd0);
        send_word({8'd255, 8'd255});
        send_word({8'd0, 8'd1});
        in_valid <= 1'b0;

        // High write bits are dropped by each register narrower than the write data.
        settle();
        apply_settings(8'hE2, 8'd8, 8'hFF, 8'h80, 8'h80, 8'hFF);
        send_word({8'd85, 8'd170});
        send_word({8'd170, 8'd85});
        in_valid <= 1'b0;

        settle();
        apply_settings(8'd1, 8'd1, 8'd16, 8'd8, 8'd100, 8'd120);
        send_word({8'd7, 8'd13});
        in_valid <= 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            if (p == 0)
                lim = 8'h00;
            else if (p == 3)
                lim = 8'd16;
            else if (p == 6)
                lim = 8'hFF;
            else
                lim = {3'($urandom), 5'($urandom_range(1, 4))};
            case ($urandom_range(0, 2))
                0:       guar = 8'd0;
                1:       guar = 8'($urandom_range(0, 8));
                default: guar = 8'($urandom);
            endcase
            tbytes = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
            rbytes = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
            apply_settings(lim, guar, tbytes, rbytes, 8'($urandom), 8'($urandom));
            run_items(PHASE_WORDS, (p == 2) ? 60 : -1, (p == 4) ? 100 : -1);
        end

        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
